@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and defaults for the pipelined prime sieve: the token that
// travels along the cell chain and the sequencer states.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int unsigned STAGES_DEF     = 16;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // One candidate bit on its way down the chain, MSB first.
  typedef struct packed {
    logic vld;    // token carries a bit
    logic first;  // most significant bit of the candidate
    logic last;   // least significant bit of the candidate
    logic dbit;   // the candidate bit itself
    logic kill;   // an earlier filled cell divides the candidate
  } sieve_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_RESULT
  } seq_state_t;

endpackage

@@ rtl/pipelined_prime_sieve.sv @@
// ----------------------------------------------------------------------------
// pipelined_prime_sieve
// Trial-division prime sieve built as a chain of divisor cells.
// ----------------------------------------------------------------------------
// Candidates enter one at a time. A candidate below two is dropped in the
// cycle it is accepted (a restart flag still empties the stages). Any other
// candidate is shifted MSB first into a chain of STAGES cells; each cell holds
// a stored prime and forms the remainder of the candidate bit-serially, and a
// kill flag rides along with the last bit once any filled cell finds a zero
// remainder. The block accepts no new candidate while one is in flight: its
// bits are fed serially and its last bit must pass the whole chain. A survivor
// is emitted; it is stored in the next empty cell, or flagged as overflow when
// all cells are filled. The output register lets a new transaction be
// accepted while the previous result still waits.
// ----------------------------------------------------------------------------
module pipelined_prime_sieve #(
  parameter int unsigned STAGES     = pps_pkg::STAGES_DEF,
  parameter int unsigned VALUE_BITS = pps_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_candidate,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_prime_value,
  output logic                  out_overflow
);

  localparam int unsigned CNT_W = $clog2(STAGES + 1);
  localparam int unsigned BIT_W = $clog2(VALUE_BITS);

  pps_pkg::seq_state_t   state_r, state_nxt;
  logic [CNT_W-1:0]      filled_r, filled_nxt;
  logic [VALUE_BITS-1:0] cand_r, cand_nxt;
  logic [VALUE_BITS-1:0] shift_r, shift_nxt;
  logic [BIT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  in_accept;
  logic                  out_free;
  logic                  store_en;
  pps_pkg::sieve_tok_t   feed_tok;
  pps_pkg::sieve_tok_t   tok [STAGES+1];

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer: feed the candidate bits, wait for the tail, then emit.
  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    cand_nxt      = cand_r;
    shift_nxt     = shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    store_en      = 1'b0;
    in_stall      = 1'b1;
    feed_tok      = '0;

    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_accept) begin
          if (in_restart) begin
            filled_nxt = '0;
          end
          // Drop candidates below two here; the chain never sees them.
          if (in_candidate[VALUE_BITS-1:1] != '0) begin
            cand_nxt    = in_candidate;
            shift_nxt   = in_candidate;
            bit_cnt_nxt = '0;
            state_nxt   = pps_pkg::ST_FEED;
          end
        end
      end
      pps_pkg::ST_FEED: begin
        feed_tok.vld   = 1'b1;
        feed_tok.first = (bit_cnt_r == '0);
        feed_tok.last  = (bit_cnt_r == BIT_W'(VALUE_BITS - 1));
        feed_tok.dbit  = shift_r[VALUE_BITS-1];
        shift_nxt      = {shift_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt    = bit_cnt_r + BIT_W'(1);
        if (feed_tok.last) begin
          state_nxt = pps_pkg::ST_DRAIN;
        end
      end
      pps_pkg::ST_DRAIN: begin
        if (tok[STAGES].vld && tok[STAGES].last) begin
          state_nxt = tok[STAGES].kill ? pps_pkg::ST_IDLE : pps_pkg::ST_RESULT;
        end
      end
      pps_pkg::ST_RESULT: begin
        // Hold until the output register is free, then emit and store.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = cand_r;
          out_ovf_nxt   = (filled_r == CNT_W'(STAGES));
          if (filled_r != CNT_W'(STAGES)) begin
            store_en   = 1'b1;
            filled_nxt = filled_r + CNT_W'(1);
          end
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  assign tok[0] = feed_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pps_pkg::ST_IDLE;
      filled_r    <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    shift_r     <= shift_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Chain of divisor cells; a cell is live once the fill count passes it.
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    pps_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .tok_in (tok[i]),
      .filled (filled_r > CNT_W'(i)),
      .wr_en  (store_en && (filled_r == CNT_W'(i))),
      .wr_data(cand_r),
      .tok_out(tok[i+1])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_value_r;
  assign out_overflow    = out_ovf_r;

endmodule

@@ rtl/pps_cell.sv @@
// ----------------------------------------------------------------------------
// pps_cell
// One sieve stage: holds a divisor and forms the remainder of the candidate
// one bit per cycle, handing the bit stream on to the next stage.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int unsigned VALUE_BITS = pps_pkg::VALUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pps_pkg::sieve_tok_t     tok_in,
  input  logic                    filled,
  input  logic                    wr_en,
  input  logic [VALUE_BITS-1:0]   wr_data,
  output pps_pkg::sieve_tok_t     tok_out
);

  logic [VALUE_BITS-1:0] div_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] rem_nxt;
  pps_pkg::sieve_tok_t   tok_r;
  pps_pkg::sieve_tok_t   tok_nxt;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic [VALUE_BITS:0]   reduced;
  logic                  is_zero;

  // Restoring division step: bring in the next bit, subtract if it fits.
  always_comb begin
    shifted = tok_in.first ? {{VALUE_BITS{1'b0}}, tok_in.dbit} : {rem_r, tok_in.dbit};
    diff    = shifted - {1'b0, div_r};
    reduced = (filled && (shifted >= {1'b0, div_r})) ? diff : shifted;
    is_zero = (reduced == '0);
    rem_nxt = tok_in.vld ? reduced[VALUE_BITS-1:0] : rem_r;
    tok_nxt      = tok_in;
    tok_nxt.kill = tok_in.kill | (tok_in.vld & tok_in.last & filled & is_zero);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (wr_en) begin
      div_r <= wr_data;
    end
  end

  assign tok_out = tok_r;

endmodule
